### hw/rtl/ftpd_pkg.sv
`default_nettype none
// -----------------------------------------------------------------------------
// ftpd_pkg
// Shared constants and types of the force/torque packet deframer.
// -----------------------------------------------------------------------------
package ftpd_pkg;

  // Packet framing
  localparam int unsigned PacketBytesDefault = 19;
  localparam logic [7:0]  StartByte          = 8'h55;
  localparam logic [7:0]  EndByte            = 8'hAA;

  // Six scaled words: three force, three torque
  localparam int unsigned ValueCount = 6;
  localparam int unsigned ForceCount = 3;
  localparam int unsigned IdxW       = $clog2(ValueCount);

  // Payload byte positions that carry the six big-endian words
  localparam int unsigned WordFirstPos = 2;
  localparam int unsigned WordLastPos  = WordFirstPos + 2 * ValueCount - 1;

  // Gain widths and reset values (unsigned Q0.16)
  localparam int unsigned GainW           = 16;
  localparam int unsigned ValueW          = 32;
  localparam logic [GainW-1:0] ForceGainRst  = 16'd1311;
  localparam logic [GainW-1:0] TorqueGainRst = 16'd33;

  // APB
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned ApbAddrW = 3;

  typedef enum logic [1:0] {
    STATUS_GOOD    = 2'd0,
    STATUS_BAD_SUM = 2'd1,
    STATUS_NO_END  = 2'd2
  } status_e;

  typedef enum logic {
    REG_FORCE_GAIN  = 1'b0,
    REG_TORQUE_GAIN = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_HUNT    = 2'b01,
    ST_COLLECT = 2'b10
  } state_e;

endpackage
`default_nettype wire

### hw/rtl/ftpd_scale.sv
`default_nettype none
// -----------------------------------------------------------------------------
// ftpd_scale
// Signed 16-bit word times unsigned Q0.16 gain, exact signed Q15.16 product.
// -----------------------------------------------------------------------------
module ftpd_scale (
  input  wire logic [7:0]                    hi_i,
  input  wire logic [7:0]                    lo_i,
  input  wire logic [ftpd_pkg::GainW-1:0]    gain_i,
  output logic      [ftpd_pkg::ValueW-1:0]   prod_o
);

  logic signed [15:0]                 word;
  logic signed [ftpd_pkg::GainW:0]    gain_s;
  logic signed [ftpd_pkg::ValueW:0]   full;

  assign word   = $signed({hi_i, lo_i});
  assign gain_s = $signed({1'b0, gain_i});
  assign full   = (ftpd_pkg::ValueW+1)'(word) * (ftpd_pkg::ValueW+1)'(gain_s);
  assign prod_o = full[ftpd_pkg::ValueW-1:0];

endmodule
`default_nettype wire

### hw/rtl/force_torque_packet_deframer.sv
`default_nettype none
// -----------------------------------------------------------------------------
// force_torque_packet_deframer
// Hunts for start byte 0x55 in a serial byte stream, collects one packet,
// scales six big-endian words by force and torque gains and reports status.
// -----------------------------------------------------------------------------
// Result: the result of a packet is registered when its last byte is accepted.
// Throughput: one byte per cycle unless the input stalls; bytes never wait on the scaling multiplier.
// Backpressure: input stalls only on a packet's last byte while the result
//   register still holds an untaken result that the output side stalls.
// Reset: asynchronous, active low; returns to hunting, drops any pending
//   result and restores both gains to their default values.
// -----------------------------------------------------------------------------
module force_torque_packet_deframer #(
  parameter int unsigned PACKET_BYTES = ftpd_pkg::PacketBytesDefault
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // APB configuration port
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [ftpd_pkg::ApbAddrW-1:0]  paddr,
  input  wire logic [ftpd_pkg::ApbDataW-1:0]  pwdata,
  output logic      [ftpd_pkg::ApbDataW-1:0]  prdata,
  output logic                                pready,
  // Byte input channel
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [7:0]                     rx_byte_i,
  // Result channel
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic      [1:0]                     status_o,
  output logic signed [ftpd_pkg::ValueW-1:0]  force_x_o,
  output logic signed [ftpd_pkg::ValueW-1:0]  force_y_o,
  output logic signed [ftpd_pkg::ValueW-1:0]  force_z_o,
  output logic signed [ftpd_pkg::ValueW-1:0]  torque_x_o,
  output logic signed [ftpd_pkg::ValueW-1:0]  torque_y_o,
  output logic signed [ftpd_pkg::ValueW-1:0]  torque_z_o
);

  // Byte position counter: holds the index of the next packet byte.
  localparam int unsigned PosW = $clog2(PACKET_BYTES);
  localparam logic [PosW-1:0] LastPos  = PosW'(PACKET_BYTES - 1);
  localparam logic [PosW-1:0] SumPos   = PosW'(PACKET_BYTES - 2);
  localparam logic [PosW-1:0] SumLast  = PosW'(PACKET_BYTES - 3);
  localparam logic [PosW-1:0] WordFrst = PosW'(ftpd_pkg::WordFirstPos);
  localparam logic [PosW-1:0] WordLst  = PosW'(ftpd_pkg::WordLastPos);
  localparam logic [PosW-1:0] FirstLo  = PosW'(ftpd_pkg::WordFirstPos + 1);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [ftpd_pkg::GainW-1:0] force_gain_q, torque_gain_q;
  logic                       cfg_wr;
  ftpd_pkg::reg_idx_e         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = ftpd_pkg::reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      force_gain_q  <= ftpd_pkg::ForceGainRst;
      torque_gain_q <= ftpd_pkg::TorqueGainRst;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        ftpd_pkg::REG_FORCE_GAIN:  force_gain_q  <= pwdata[ftpd_pkg::GainW-1:0];
        ftpd_pkg::REG_TORQUE_GAIN: torque_gain_q <= pwdata[ftpd_pkg::GainW-1:0];
        default: ;
      endcase
    end
  end

  // Read back: zero-extend the selected gain.
  always_comb begin
    unique case (cfg_idx)
      ftpd_pkg::REG_FORCE_GAIN:
        prdata = ftpd_pkg::ApbDataW'(force_gain_q);
      ftpd_pkg::REG_TORQUE_GAIN:
        prdata = ftpd_pkg::ApbDataW'(torque_gain_q);
      default:
        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Framing state
  // ---------------------------------------------------------------------------
  ftpd_pkg::state_e state_q, state_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [7:0]       sum_q, sum_d;
  logic [7:0]       hold_q;
  logic [7:0]       rx_sum_q;
  logic [ftpd_pkg::ValueW-1:0] scaled_q [ftpd_pkg::ValueCount];

  logic in_acc;
  logic collecting;
  logic at_last;
  logic out_take;

  assign collecting = (state_q == ftpd_pkg::ST_COLLECT);
  assign at_last    = collecting && (pos_q >= LastPos);
  // A result is taken at the edge where it is valid and not stalled.
  assign out_take   = out_valid_o & ~out_stall_i;

  // Stall only the closing byte, and only while the result register is
  // still occupied and will not empty this cycle.
  assign in_stall_o = at_last & out_valid_o & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;

  // Word assembly: even positions latch the high byte, odd ones complete a
  // word and scale it with the gain of its group.
  logic                       word_hi;
  logic                       word_lo;
  logic [PosW-1:0]            pos_off;
  logic [ftpd_pkg::IdxW-1:0]  word_idx;
  logic [ftpd_pkg::GainW-1:0] word_gain;
  logic [ftpd_pkg::ValueW-1:0] word_prod;

  assign word_hi  = collecting && (pos_q >= WordFrst) && (pos_q <= WordLst) && !pos_q[0];
  assign word_lo  = collecting && (pos_q >= FirstLo) && (pos_q <= WordLst) && pos_q[0];
  assign pos_off  = pos_q - FirstLo;
  assign word_idx = ftpd_pkg::IdxW'(pos_off >> 1);
  assign word_gain = (word_idx < ftpd_pkg::IdxW'(ftpd_pkg::ForceCount)) ?
                     force_gain_q : torque_gain_q;

  ftpd_scale u_scale (
    .hi_i   (hold_q),
    .lo_i   (rx_byte_i),
    .gain_i (word_gain),
    .prod_o (word_prod)
  );

  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    sum_d   = sum_q;
    unique case (state_q)
      ftpd_pkg::ST_HUNT: begin
        // Wait for the start byte; restart the checksum.
        if (rx_byte_i == ftpd_pkg::StartByte) begin
          state_d = ftpd_pkg::ST_COLLECT;
          pos_d   = PosW'(1);
          sum_d   = '0;
        end
      end
      ftpd_pkg::ST_COLLECT: begin
        // Sum payload bytes up to the one before the checksum byte.
        if (pos_q <= SumLast) begin
          sum_d = sum_q + rx_byte_i;
        end
        if (at_last) begin
          state_d = ftpd_pkg::ST_HUNT;
          pos_d   = '0;
        end else begin
          pos_d = pos_q + PosW'(1);
        end
      end
      default: begin
        state_d = ftpd_pkg::ST_HUNT;
        pos_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ftpd_pkg::ST_HUNT;
      pos_q   <= '0;
      sum_q   <= '0;
    end else if (in_acc) begin
      state_q <= state_d;
      pos_q   <= pos_d;
      sum_q   <= sum_d;
    end
  end

  // Payload registers: no reset, every one is written before it is read.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      if (word_hi) begin
        hold_q <= rx_byte_i;
      end
      if (word_lo) begin
        scaled_q[word_idx] <= word_prod;
      end
      if (collecting && (pos_q == SumPos)) begin
        rx_sum_q <= rx_byte_i;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  ftpd_pkg::status_e status_d, status_q;
  logic              out_valid_q;
  logic [ftpd_pkg::ValueW-1:0] out_val_q [ftpd_pkg::ValueCount];

  // Checksum mismatch wins over a missing end byte.
  always_comb begin
    priority if (rx_sum_q != sum_q) begin
      status_d = ftpd_pkg::STATUS_BAD_SUM;
    end else if (rx_byte_i != ftpd_pkg::EndByte) begin
      status_d = ftpd_pkg::STATUS_NO_END;
    end else begin
      status_d = ftpd_pkg::STATUS_GOOD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc && at_last) begin
      out_valid_q <= 1'b1;
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && at_last) begin
      status_q <= status_d;
      for (int i = 0; i < ftpd_pkg::ValueCount; i++) begin
        // Drop the values of a rejected packet.
        out_val_q[i] <= (status_d == ftpd_pkg::STATUS_GOOD) ? scaled_q[i] : '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign force_x_o   = $signed(out_val_q[0]);
  assign force_y_o   = $signed(out_val_q[1]);
  assign force_z_o   = $signed(out_val_q[2]);
  assign torque_x_o  = $signed(out_val_q[3]);
  assign torque_y_o  = $signed(out_val_q[4]);
  assign torque_z_o  = $signed(out_val_q[5]);

`ifndef SYNTHESIS
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= LastPos)
    else $error("byte position beyond packet length");

  a_hunt_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ftpd_pkg::ST_HUNT) |-> (pos_q == '0))
    else $error("position not cleared while hunting");

  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && at_last) |=> out_valid_o)
    else $error("closing byte produced no result");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && at_last))
    else $error("input stalled without a pending result");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ftpd_pkg::STATUS_GOOD)) |->
      (force_x_o == '0 && force_y_o == '0 && force_z_o == '0 &&
       torque_x_o == '0 && torque_y_o == '0 && torque_z_o == '0))
    else $error("rejected packet carries nonzero values");
`endif

endmodule
`default_nettype wire

### verif/tb_force_torque_packet_deframer.sv
// ----------------------------------------------------------------------------
// Testbench for the force/torque packet deframer
// Streams serial bytes (framed packets, flawed packets, truncated packets and
// line noise) into the deframer under random source gaps and sink stalls.
// Every request is also fed to a cycle-free predictor, and each result is
// checked field by field against the oldest prediction. Gains are changed
// over the APB port between phases, sometimes in the middle of a packet.
// ----------------------------------------------------------------------------
module tb_force_torque_packet_deframer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PktLen        = ftpd_pkg::PacketBytesDefault;
  localparam int unsigned NumPhases     = 6;
  localparam int unsigned BytesPerPhase = 330;
  localparam int unsigned LongHoldLen   = 300;

  // Kinds of damage a generated packet can carry
  typedef enum logic [1:0] {
    FLAW_NONE = 2'd0,
    FLAW_SUM  = 2'd1,
    FLAW_END  = 2'd2,
    FLAW_BOTH = 2'd3
  } flaw_e;

  // One deframer result; val[0] is force_x, val[5] is torque_z
  typedef struct packed {
    ftpd_pkg::status_e status;
    logic [5:0][31:0]  val;
  } frame_result_t;

  // --------------------------------------------------------------------------
  // Clock, reset and DUT ports. Every input starts at a known value.
  // --------------------------------------------------------------------------
  logic                           clk_i       = 1'b0;
  logic                           rst_ni      = 1'b0;
  logic                           psel        = 1'b0;
  logic                           penable     = 1'b0;
  logic                           pwrite      = 1'b0;
  logic [ftpd_pkg::ApbAddrW-1:0]  paddr       = '0;
  logic [ftpd_pkg::ApbDataW-1:0]  pwdata      = '0;
  logic [ftpd_pkg::ApbDataW-1:0]  prdata;
  logic                           pready;
  logic                           in_valid_i  = 1'b0;
  logic                           in_stall_o;
  logic [7:0]                     rx_byte_i   = '0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  logic [1:0]                     status_o;
  logic signed [31:0]             force_x_o, force_y_o, force_z_o;
  logic signed [31:0]             torque_x_o, torque_y_o, torque_z_o;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  force_torque_packet_deframer #(
    .PACKET_BYTES (PktLen)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .rx_byte_i   (rx_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .force_x_o   (force_x_o),
    .force_y_o   (force_y_o),
    .force_z_o   (force_z_o),
    .torque_x_o  (torque_x_o),
    .torque_y_o  (torque_y_o),
    .torque_z_o  (torque_z_o)
  );

  // --------------------------------------------------------------------------
  // Shared bookkeeping
  // --------------------------------------------------------------------------
  logic [7:0]     pending_bytes [$];   // bytes waiting for the sender
  frame_result_t  frame_results_q [$]; // predicted results, oldest first
  logic           took = 1'b0;         // byte request accepted at last rising edge
  int unsigned    mismatches    = 0;
  int unsigned    results_seen  = 0;
  int unsigned    bytes_taken   = 0;
  int unsigned    stall_cycles  = 0;
  int unsigned    gain_settings = 1;
  int unsigned    status_seen [3] = '{0, 0, 0};

  // --------------------------------------------------------------------------
  // Predictor state: the deframer as this testbench sees it
  // --------------------------------------------------------------------------
  logic [15:0]       cur_force_gain  = ftpd_pkg::ForceGainRst;
  logic [15:0]       cur_torque_gain = ftpd_pkg::TorqueGainRst;
  logic              hunting_done    = 1'b0;  // high while inside a packet
  logic [4:0]        pkt_pos         = '0;    // index of the next packet byte
  logic [7:0]        sum_acc         = '0;
  logic [7:0]        hi_byte         = '0;
  logic [7:0]        sum_field       = '0;
  logic [5:0][31:0]  scaled_words    = '0;

  // Append one byte to the sender's queue.
  task automatic enqueue_byte(input logic [7:0] b);
    pending_bytes = {pending_bytes, b};
  endtask

  // Advance the predictor by one accepted byte; queue a result at packet end.
  task automatic deframe_byte(input logic [7:0] b);
    frame_result_t want;
    int            raw;
    int            gain_ext;
    int unsigned   idx;
    if (!hunting_done) begin
      // hunt: only the start byte opens a packet
      if (b == ftpd_pkg::StartByte) begin
        hunting_done = 1'b1;
        pkt_pos      = 5'd1;
        sum_acc      = '0;
      end
      return;
    end
    if (pkt_pos >= 1 && pkt_pos <= PktLen - 3) sum_acc = sum_acc + b;
    if (pkt_pos >= ftpd_pkg::WordFirstPos && pkt_pos <= ftpd_pkg::WordLastPos) begin
      if (!pkt_pos[0]) begin
        hi_byte = b;
      end else begin
        // low byte completes a word; scale it with the gain in force now
        idx      = (int'(pkt_pos) - 3) >> 1;
        raw      = $signed({hi_byte, b});
        gain_ext = {16'd0, (idx < ftpd_pkg::ForceCount) ? cur_force_gain : cur_torque_gain};
        scaled_words[idx] = raw * gain_ext;
      end
    end
    if (pkt_pos == PktLen - 2) sum_field = b;
    if (pkt_pos >= PktLen - 1) begin
      // checksum is judged before the end byte
      if (sum_field != sum_acc)         want.status = ftpd_pkg::STATUS_BAD_SUM;
      else if (b != ftpd_pkg::EndByte)  want.status = ftpd_pkg::STATUS_NO_END;
      else                              want.status = ftpd_pkg::STATUS_GOOD;
      want.val = (want.status == ftpd_pkg::STATUS_GOOD) ? scaled_words : '0;
      frame_results_q = {frame_results_q, want};
      hunting_done = 1'b0;
      pkt_pos      = '0;
      return;
    end
    pkt_pos = pkt_pos + 5'd1;
  endtask

  task automatic flag_mismatch(input string field, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    mismatches++;
    if (mismatches <= 10)
      $display("[%0t] result %0d, %s: expected %h, got %h",
               $realtime, results_seen, field, exp_v, act_v);
  endtask

  // --------------------------------------------------------------------------
  // Monitor: sample both channels at the rising edge. Check results first,
  // then feed the accepted byte to the predictor.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : watch
    frame_result_t got;
    frame_result_t want;
    if (!rst_ni) begin
      took <= 1'b0;
    end else begin
      took <= in_valid_i && !in_stall_o;
      if (in_valid_i && in_stall_o) stall_cycles++;
      if (out_valid_o && !out_stall_i) begin
        got.status = ftpd_pkg::status_e'(status_o);
        got.val    = {torque_z_o, torque_y_o, torque_x_o,
                      force_z_o, force_y_o, force_x_o};
        if (frame_results_q.size() == 0) begin
          flag_mismatch("unexpected result, status", 'x, 32'(status_o));
        end else begin
          want = frame_results_q.pop_front();
          if (got.status !== want.status)
            flag_mismatch("status", 32'(want.status), 32'(got.status));
          for (int j = 0; j < ftpd_pkg::ValueCount; j++) begin
            if (got.val[j] !== want.val[j]) begin
              case (j)
                0:       flag_mismatch("force_x",  want.val[j], got.val[j]);
                1:       flag_mismatch("force_y",  want.val[j], got.val[j]);
                2:       flag_mismatch("force_z",  want.val[j], got.val[j]);
                3:       flag_mismatch("torque_x", want.val[j], got.val[j]);
                4:       flag_mismatch("torque_y", want.val[j], got.val[j]);
                default: flag_mismatch("torque_z", want.val[j], got.val[j]);
              endcase
            end
          end
        end
        if (status_o < 3) status_seen[status_o]++;
        results_seen++;
      end
      if (in_valid_i && !in_stall_o) begin
        bytes_taken++;
        deframe_byte(rx_byte_i);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Byte sender: hold a request until it is taken, then pop the next byte
  // after a random gap. Mostly short gaps, a few long ones, and calm stretches
  // with no gaps at all.
  // --------------------------------------------------------------------------
  int unsigned gap_left  = 0;
  int unsigned calm_left = 0;

  always @(negedge clk_i) begin : sender
    int unsigned r;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !took) begin
      // hold: request still pending, payload stays put
    end else if (gap_left != 0) begin
      in_valid_i <= 1'b0;
      gap_left   <= gap_left - 1;
    end else if (pending_bytes.size() != 0) begin
      rx_byte_i  <= pending_bytes.pop_front();
      in_valid_i <= 1'b1;
      r = $urandom_range(0, 15);
      if (calm_left != 0) begin
        calm_left <= calm_left - 1;
        gap_left  <= 0;
      end else if (r < 8)  gap_left <= 0;
      else if (r < 13)     gap_left <= $urandom_range(1, 3);
      else if (r == 13)    gap_left <= $urandom_range(8, 40);
      else                 calm_left <= $urandom_range(20, 60);
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Result receiver: random stall runs, plus one long hold-off counted here
  // once a few results have passed, so the result slot fills and the deframer
  // pushes back on its byte input while the sender keeps offering.
  // --------------------------------------------------------------------------
  int unsigned hold_left = 0;
  int unsigned run_left  = 0;
  logic        held_once = 1'b0;

  always @(negedge clk_i) begin : receiver
    int unsigned r;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (!held_once && results_seen >= 3) begin
      held_once   <= 1'b1;
      hold_left   <= LongHoldLen - 1;
      out_stall_i <= 1'b1;
    end else if (run_left != 0) begin
      run_left <= run_left - 1;
    end else begin
      r = $urandom_range(0, 15);
      if (r < 8) begin
        out_stall_i <= 1'b0;
        run_left    <= $urandom_range(0, 5);
      end else if (r < 13) begin
        out_stall_i <= 1'b1;
        run_left    <= $urandom_range(0, 2);
      end else if (r == 13) begin
        out_stall_i <= 1'b1;
        run_left    <= $urandom_range(10, 40);
      end else begin
        out_stall_i <= 1'b0;
        run_left    <= $urandom_range(30, 80);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Build one packet around six words; damage the checksum and/or end byte.
  task automatic make_packet(input flaw_e flaw, input logic [5:0][15:0] words,
                             output logic [7:0] pkt [PktLen]);
    logic [7:0] chk;
    logic [7:0] bad_end;
    chk    = '0;
    pkt[0] = ftpd_pkg::StartByte;
    pkt[1] = 8'($urandom);
    for (int k = 0; k < ftpd_pkg::ValueCount; k++) begin
      pkt[ftpd_pkg::WordFirstPos + 2*k]     = words[k][15:8];
      pkt[ftpd_pkg::WordFirstPos + 2*k + 1] = words[k][7:0];
    end
    for (int p = ftpd_pkg::WordLastPos + 1; p < PktLen - 2; p++) pkt[p] = 8'($urandom);
    for (int p = 1; p <= PktLen - 3; p++) chk = chk + pkt[p];
    if (flaw == FLAW_SUM || flaw == FLAW_BOTH) chk = chk + 8'($urandom_range(1, 255));
    pkt[PktLen-2] = chk;
    bad_end = 8'($urandom_range(0, 254));
    if (bad_end >= ftpd_pkg::EndByte) bad_end = bad_end + 8'd1;
    pkt[PktLen-1] = (flaw == FLAW_END || flaw == FLAW_BOTH) ? bad_end : ftpd_pkg::EndByte;
  endtask

  // Wait until every byte is taken and every predicted result has come out,
  // then let the deframer settle. Check at the rising edge, where the sender's
  // queue and request are stable.
  task automatic wait_idle(input int unsigned settle);
    do @(posedge clk_i);
    while (pending_bytes.size() != 0 || in_valid_i || frame_results_q.size() != 0);
    repeat (settle) @(negedge clk_i);
  endtask

  // APB write: setup cycle, then access until pready; update the predictor.
  task automatic write_gain(input ftpd_pkg::reg_idx_e idx, input logic [15:0] value);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = {16'd0, value};
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (idx == ftpd_pkg::REG_FORCE_GAIN) cur_force_gain = value;
    else                                 cur_torque_gain = value;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [7:0]        pkt [PktLen];
    logic [5:0][15:0]  words;
    logic [7:0]        nb;
    flaw_e             flaw;
    int unsigned       r;
    int unsigned       split;
    int unsigned       cut;
    int unsigned       phase_bytes;

    split = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: line noise while hunting, then one good packet with the
    // extreme words at the reset gains.
    enqueue_byte(8'h00);
    enqueue_byte(8'hFF);
    enqueue_byte(ftpd_pkg::EndByte);
    words = {16'h8000, 16'h0001, 16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000};
    make_packet(FLAW_NONE, words, pkt);
    foreach (pkt[p]) enqueue_byte(pkt[p]);

    for (int ph = 0; ph < NumPhases; ph++) begin
      if (ph > 0) begin
        // reconfigure while idle; a packet may be half received right now
        wait_idle(4);
        case (ph)
          1: begin
            write_gain(ftpd_pkg::REG_FORCE_GAIN, 16'hFFFF);
            write_gain(ftpd_pkg::REG_TORQUE_GAIN, 16'h0000);
          end
          2: begin
            write_gain(ftpd_pkg::REG_FORCE_GAIN, 16'h0000);
            write_gain(ftpd_pkg::REG_TORQUE_GAIN, 16'hFFFF);
          end
          3: begin
            write_gain(ftpd_pkg::REG_FORCE_GAIN, 16'($urandom));
            write_gain(ftpd_pkg::REG_TORQUE_GAIN, 16'($urandom));
          end
          4: begin
            write_gain(ftpd_pkg::REG_FORCE_GAIN, 16'hFFFF);
            write_gain(ftpd_pkg::REG_TORQUE_GAIN, 16'hFFFF);
          end
          default: begin
            write_gain(ftpd_pkg::REG_FORCE_GAIN, ftpd_pkg::ForceGainRst);
            write_gain(ftpd_pkg::REG_TORQUE_GAIN, ftpd_pkg::TorqueGainRst);
          end
        endcase
        gain_settings++;
        @(posedge clk_i);
        // finish the packet that was split across the gain change
        for (int p = split; p < PktLen; p++) enqueue_byte(pkt[p]);
      end

      phase_bytes = 0;
      while (phase_bytes < BytesPerPhase) begin
        r = $urandom_range(0, 9);
        if (r == 0) begin
          // raw noise burst, start bytes included
          repeat ($urandom_range(1, 20)) enqueue_byte(8'($urandom));
        end else begin
          // a little inter-packet noise, mostly free of start bytes
          repeat ($urandom_range(0, 3)) begin
            nb = 8'($urandom);
            if (nb == ftpd_pkg::StartByte && $urandom_range(0, 3) != 0) nb = ~nb;
            enqueue_byte(nb);
          end
          for (int k = 0; k < ftpd_pkg::ValueCount; k++) begin
            case ($urandom_range(0, 7))
              0:       words[k] = 16'h8000;
              1:       words[k] = 16'h7FFF;
              2:       words[k] = 16'hFFFF;
              3:       words[k] = 16'h0000;
              4:       words[k] = 16'h0001;
              default: words[k] = 16'($urandom);
            endcase
          end
          r    = $urandom_range(0, 9);
          flaw = (r < 7) ? FLAW_NONE : flaw_e'(r - 6);
          make_packet(flaw, words, pkt);
          // now and then drop the tail so the next packet is swallowed
          cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, PktLen - 1) : PktLen;
          for (int p = 0; p < cut; p++) enqueue_byte(pkt[p]);
          phase_bytes += cut;
        end
      end

      if (ph < NumPhases - 1) begin
        // open a packet and leave it half done for the next gain setting
        for (int k = 0; k < ftpd_pkg::ValueCount; k++) words[k] = 16'($urandom);
        make_packet(flaw_e'($urandom_range(0, 3)), words, pkt);
        split = $urandom_range(1, PktLen - 1);
        for (int p = 0; p < split; p++) enqueue_byte(pkt[p]);
      end
    end

    wait_idle(8);
    $display("covered %0d bytes and %0d packets (%0d good, %0d bad checksum, %0d no end)",
             bytes_taken, results_seen, status_seen[ftpd_pkg::STATUS_GOOD],
             status_seen[ftpd_pkg::STATUS_BAD_SUM], status_seen[ftpd_pkg::STATUS_NO_END]);
    $display("over %0d gain settings; byte input pushed back on %0d cycles",
             gain_settings, stall_cycles);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #(20_000_000);
    $display("timeout with %0d results still expected", frame_results_q.size());
    $display("status: fail");
    $finish;
  end

endmodule
